// ===== design/lecs_pkg.sv =====
// Shared types and constants for the rebuild-lifetime statistics scheduler.
// Used by lecs_ctrl, lecs_dp and lifetime_ema_check_scheduler_unit. No dependencies.
`default_nettype none

package lecs_pkg;

  localparam int STEP_W     = 48;
  localparam int ATOMS_W    = 24;
  localparam int CHECK_W    = 50;
  localparam int LIFE_OUT_W = 20;
  localparam int MEAN_OUT_W = 28;
  localparam int COUNT_W    = 32;
  localparam int SUM_W      = 48;
  localparam int SQSUM_W    = 63;
  localparam int TOTAL_W    = 48;

  // EMA denominator; the 0.9 weight is applied as (x << 3) + x before dividing
  localparam logic [4:0] EMA_DEN = 5'd10;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_RESET  = 2'd1,
    OP_INIT   = 2'd2
  } op_t;

  typedef struct packed {
    logic capture;
    logic apply;
    logic lt_calc;
    logic mul_load;
    logic mul_dd;
    logic mul_step;
    logic stats;
    logic div_load;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic chk_d;
    logic chk_t;
    logic chk_sum;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t op;
  } status_t;

endpackage

`default_nettype wire

// ===== design/lecs_ctrl.sv =====
// Sequencer for the lifetime statistics scheduler: handshakes and step counts.
// Depends on lecs_pkg; drives the command word of lecs_dp.
`default_nettype none

module lecs_ctrl #(
  parameter int LIFETIME_BITS = 20,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  output      logic              out_valid,
  input  wire logic              out_ready,
  input  wire lecs_pkg::status_t status,
  output      lecs_pkg::cmd_t    cmd
);

  localparam int MW        = LIFETIME_BITS + FRACTION_BITS;
  localparam int VW        = 2 * MW;
  localparam int MBW       = 2 * ((MW + 1) / 2);
  localparam int DNW       = 4 * ((VW + 4 + 3) / 4);
  localparam int MUL_STEPS = MBW / 2;
  localparam int DIV_STEPS = DNW / 4;
  localparam int SQRT_STEPS = MW;
  localparam int CNT_W     = $clog2(MW);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_APPLY, S_LIFE, S_MUL_LT_LD, S_MUL_LT, S_STATS,
    S_MUL_DD_LD, S_MUL_DD, S_DIV_LD, S_DIV, S_SQRT_LD, S_SQRT,
    S_CHK_D, S_CHK_T, S_CHK_SUM, S_FIN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECODE;
        end
        S_DECODE: begin
          if (status.op == lecs_pkg::OP_UPDATE) state <= S_LIFE;
          else state <= S_APPLY;
        end
        S_APPLY: state <= S_FIN;
        S_LIFE: state <= S_MUL_LT_LD;
        S_MUL_LT_LD: begin
          cnt   <= CNT_W'(MUL_STEPS - 1);
          state <= S_MUL_LT;
        end
        S_MUL_LT: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= S_STATS;
        end
        S_STATS: state <= S_MUL_DD_LD;
        S_MUL_DD_LD: begin
          cnt   <= CNT_W'(MUL_STEPS - 1);
          state <= S_MUL_DD;
        end
        S_MUL_DD: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= S_DIV_LD;
        end
        S_DIV_LD: begin
          cnt   <= CNT_W'(DIV_STEPS - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= S_SQRT_LD;
        end
        S_SQRT_LD: begin
          cnt   <= CNT_W'(SQRT_STEPS - 1);
          state <= S_SQRT;
        end
        S_SQRT: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= S_CHK_D;
        end
        S_CHK_D: state <= S_CHK_T;
        S_CHK_T: state <= S_CHK_SUM;
        S_CHK_SUM: state <= S_FIN;
        S_FIN: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.capture   = in_valid && in_ready;
    cmd.apply     = (state == S_APPLY);
    cmd.lt_calc   = (state == S_LIFE);
    cmd.mul_load  = (state == S_MUL_LT_LD) || (state == S_MUL_DD_LD);
    cmd.mul_dd    = (state == S_MUL_DD_LD);
    cmd.mul_step  = (state == S_MUL_LT) || (state == S_MUL_DD);
    cmd.stats     = (state == S_STATS);
    cmd.div_load  = (state == S_DIV_LD);
    cmd.div_step  = (state == S_DIV);
    cmd.sqrt_load = (state == S_SQRT_LD);
    cmd.sqrt_step = (state == S_SQRT);
    cmd.chk_d     = (state == S_CHK_D);
    cmd.chk_t     = (state == S_CHK_T);
    cmd.chk_sum   = (state == S_CHK_SUM);
    cmd.out_load  = (state == S_FIN) && out_free;
  end

endmodule

`default_nettype wire

// ===== design/lecs_dp.sv =====
// Datapath for the lifetime statistics scheduler: state, counters, radix-4
// multiplier, divide-by-ten unit, square root and result registers.
// Depends on lecs_pkg; sequenced by lecs_ctrl.
`default_nettype none

module lecs_dp #(
  parameter int LIFETIME_BITS = 20,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic                                  cfg_data,
  input  wire logic [1:0]                            opcode,
  input  wire logic [lecs_pkg::STEP_W-1:0]           step,
  input  wire logic [lecs_pkg::ATOMS_W-1:0]          atoms_beyond,
  input  wire lecs_pkg::cmd_t                        cmd,
  output      lecs_pkg::status_t                     status,
  output      logic signed [lecs_pkg::CHECK_W-1:0]   next_check_step,
  output      logic [lecs_pkg::LIFE_OUT_W-1:0]       lifetime,
  output      logic [lecs_pkg::MEAN_OUT_W-1:0]       mean_lifetime,
  output      logic [lecs_pkg::MEAN_OUT_W-1:0]       sigma,
  output      logic [lecs_pkg::COUNT_W-1:0]          rebuild_count,
  output      logic [lecs_pkg::SUM_W-1:0]            lifetime_sum,
  output      logic [lecs_pkg::SQSUM_W-1:0]          lifetime_square_sum,
  output      logic [lecs_pkg::TOTAL_W-1:0]          atoms_beyond_total
);

  localparam int LB  = LIFETIME_BITS;
  localparam int FB  = FRACTION_BITS;
  localparam int MW  = LB + FB;
  localparam int VW  = 2 * MW;
  localparam int MBW = 2 * ((MW + 1) / 2);
  localparam int AW  = 2 * MBW;
  localparam int DNW = 4 * ((VW + 4 + 3) / 4);
  localparam int RW  = MW + 2;
  localparam int DW  = MW + 2;
  localparam int SW  = lecs_pkg::STEP_W;
  localparam int CW  = lecs_pkg::CHECK_W;

  // state
  logic                           every_step;
  logic [SW-1:0]                  last_step;
  logic [CW-1:0]                  check_step;
  logic [MW-1:0]                  mean;
  logic [VW-1:0]                  variance;
  logic [MW-1:0]                  root;
  logic [lecs_pkg::COUNT_W-1:0]   count;
  logic [lecs_pkg::SUM_W-1:0]     lt_sum;
  logic [lecs_pkg::SQSUM_W-1:0]   sq_sum;
  logic [lecs_pkg::TOTAL_W-1:0]   atoms_total;

  // working registers
  lecs_pkg::op_t                  op_q;
  logic [SW-1:0]                  step_q;
  logic [lecs_pkg::ATOMS_W-1:0]   atoms_q;
  logic [LB-1:0]                  lt;
  logic [MBW-1:0]                 mul_a;
  logic [MBW+1:0]                 mul_a3;
  logic [MBW-1:0]                 mul_b;
  logic [AW-1:0]                  acc;
  logic [MW-1:0]                  dd;
  logic [DNW-1:0]                 num_v;
  logic [DNW-1:0]                 num_m;
  logic [3:0]                     rem_v;
  logic [3:0]                     rem_m;
  logic [VW-1:0]                  rad;
  logic [RW-1:0]                  sq_rem;
  logic [DW-1:0]                  d_diff;
  logic [DW-1:0]                  t_q;

  // combinational
  logic [SW-1:0]                  diff;
  logic [LB-1:0]                  lt_next;
  logic [MW-1:0]                  mul_src;
  logic [MBW+1:0]                 pp;
  logic [MW-1:0]                  ltf;
  logic                           seeded;
  logic [MW-1:0]                  mean_b;
  logic [VW-1:0]                  var_b;
  logic [lecs_pkg::COUNT_W:0]     count_add;
  logic [lecs_pkg::SUM_W:0]       sum_add;
  logic [lecs_pkg::SQSUM_W+1:0]   sq_add;
  logic [lecs_pkg::TOTAL_W:0]     atoms_add;
  logic [DNW+3:0]                 div_v_next;
  logic [DNW+3:0]                 div_m_next;
  logic [RW+1:0]                  sq_r;
  logic [RW+1:0]                  sq_trial;
  logic                           sq_ge;
  logic                           d_neg;
  logic [DW-1:0]                  d_mag;
  logic [DW-1:0]                  d_quot;

  // four quotient bits of a divide by ten, quotient shifted in at the bottom
  function automatic logic [DNW+3:0] div10_digit(input logic [DNW-1:0] num,
                                                 input logic [3:0] rem);
    logic [4:0]     r;
    logic [DNW-1:0] n;
    logic [3:0]     rm;
    n  = num;
    rm = rem;
    for (int k = 0; k < 4; k++) begin
      r = {rm, n[DNW-1]};
      n = {n[DNW-2:0], 1'b0};
      if (r >= lecs_pkg::EMA_DEN) begin
        rm   = 4'(r - lecs_pkg::EMA_DEN);
        n[0] = 1'b1;
      end else begin
        rm = r[3:0];
      end
    end
    return {rm, n};
  endfunction

  assign status.op = op_q;

  assign diff = step_q - last_step;
  always_comb begin
    lt_next = '0;
    if (step_q > last_step) begin
      if (diff > SW'({LB{1'b1}})) lt_next = {LB{1'b1}};
      else lt_next = LB'(diff);
    end
  end

  assign mul_src = cmd.mul_dd ? dd : MW'(lt);

  always_comb begin
    unique case (mul_b[MBW-1 -: 2])
      2'b00: pp = '0;
      2'b01: pp = (MBW+2)'(mul_a);
      2'b10: pp = (MBW+2)'({mul_a, 1'b0});
      2'b11: pp = mul_a3;
      default: pp = '0;
    endcase
  end

  assign ltf    = MW'(lt) << FB;
  assign seeded = (mean == '0);
  assign mean_b = seeded ? ltf : mean;
  assign var_b  = seeded ? (VW'(acc) << (2 * FB - 2)) : variance;

  assign count_add = {1'b0, count} + (lecs_pkg::COUNT_W+1)'(1);
  assign sum_add   = {1'b0, lt_sum} + (lecs_pkg::SUM_W+1)'(lt);
  assign sq_add    = (lecs_pkg::SQSUM_W+2)'(sq_sum) + (lecs_pkg::SQSUM_W+2)'(acc);
  assign atoms_add = {1'b0, atoms_total} + (lecs_pkg::TOTAL_W+1)'(atoms_q);

  assign div_v_next = div10_digit(num_v, rem_v);
  assign div_m_next = div10_digit(num_m, rem_m);

  assign sq_r     = {sq_rem, rad[VW-1 -: 2]};
  assign sq_trial = (RW+2)'({root, 2'b01});
  assign sq_ge    = (sq_r >= sq_trial);

  // truncate toward zero: shift the magnitude, restore the sign
  assign d_neg  = d_diff[DW-1];
  assign d_mag  = d_neg ? (~d_diff + 1'b1) : d_diff;
  assign d_quot = d_mag >> FB;

  always_ff @(posedge clk) begin
    if (rst) begin
      every_step  <= 1'b0;
      last_step   <= '0;
      check_step  <= '0;
      mean        <= '0;
      variance    <= '0;
      root        <= '0;
      count       <= '0;
      lt_sum      <= '0;
      sq_sum      <= '0;
      atoms_total <= '0;
    end else begin
      if (cfg_write) every_step <= cfg_data;
      if (cmd.apply) begin
        priority case (op_q)
          lecs_pkg::OP_RESET, lecs_pkg::OP_INIT: begin
            mean       <= '0;
            variance   <= '0;
            root       <= '0;
            check_step <= CW'(step_q);
            last_step  <= step_q;
            if (op_q == lecs_pkg::OP_INIT) begin
              count       <= '0;
              lt_sum      <= '0;
              sq_sum      <= '0;
              atoms_total <= '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.stats) begin
        count       <= count_add[lecs_pkg::COUNT_W] ? '1 : count_add[lecs_pkg::COUNT_W-1:0];
        lt_sum      <= sum_add[lecs_pkg::SUM_W] ? '1 : sum_add[lecs_pkg::SUM_W-1:0];
        sq_sum      <= (sq_add[lecs_pkg::SQSUM_W+1 -: 2] != 2'b00) ? '1 :
                       sq_add[lecs_pkg::SQSUM_W-1:0];
        atoms_total <= atoms_add[lecs_pkg::TOTAL_W] ? '1 : atoms_add[lecs_pkg::TOTAL_W-1:0];
        mean        <= mean_b;
        variance    <= var_b;
      end
      if (cmd.sqrt_load) begin
        variance <= VW'(num_v);
        mean     <= MW'(num_m);
        root     <= '0;
      end
      if (cmd.sqrt_step) begin
        root <= {root[MW-2:0], sq_ge};
      end
      if (cmd.chk_sum) begin
        if (every_step) check_step <= CW'(step_q);
        else check_step <= CW'(step_q) + CW'($signed(t_q)) - CW'(1);
        last_step <= step_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= lecs_pkg::op_t'(opcode);
      step_q  <= step;
      atoms_q <= atoms_beyond;
    end
    if (cmd.apply) lt <= '0;
    if (cmd.lt_calc) lt <= lt_next;
    if (cmd.mul_load) begin
      mul_a  <= MBW'(mul_src);
      mul_b  <= MBW'(mul_src);
      mul_a3 <= (MBW+2)'(mul_src) + (MBW+2)'({mul_src, 1'b0});
      acc    <= '0;
    end
    if (cmd.mul_step) begin
      acc   <= (acc << 2) + AW'(pp);
      mul_b <= mul_b << 2;
    end
    if (cmd.stats) begin
      dd <= (mean_b >= ltf) ? (mean_b - ltf) : (ltf - mean_b);
    end
    if (cmd.div_load) begin
      num_v <= (DNW'(variance) << 3) + DNW'(variance) + DNW'(acc);
      num_m <= (DNW'(mean) << 3) + DNW'(mean) + DNW'(ltf);
      rem_v <= '0;
      rem_m <= '0;
    end
    if (cmd.div_step) begin
      {rem_v, num_v} <= div_v_next;
      {rem_m, num_m} <= div_m_next;
    end
    if (cmd.sqrt_load) begin
      rad    <= VW'(num_v);
      sq_rem <= '0;
    end
    if (cmd.sqrt_step) begin
      rad    <= rad << 2;
      sq_rem <= sq_ge ? RW'(sq_r - sq_trial) : RW'(sq_r);
    end
    if (cmd.chk_d) begin
      d_diff <= DW'(mean) - DW'({root, 1'b0});
    end
    if (cmd.chk_t) begin
      t_q <= d_neg ? (~d_quot + 1'b1) : d_quot;
    end
    if (cmd.out_load) begin
      next_check_step     <= check_step;
      lifetime            <= lecs_pkg::LIFE_OUT_W'(lt);
      mean_lifetime       <= lecs_pkg::MEAN_OUT_W'(mean);
      sigma               <= lecs_pkg::MEAN_OUT_W'(root);
      rebuild_count       <= count;
      lifetime_sum        <= lt_sum;
      lifetime_square_sum <= sq_sum;
      atoms_beyond_total  <= atoms_total;
    end
  end

endmodule

`default_nettype wire

// ===== design/lifetime_ema_check_scheduler_unit.sv =====
// Top level of the rebuild-lifetime statistics and next-check scheduler.
// Depends on lecs_pkg, lecs_ctrl and lecs_dp.
//
// One word in gives one word out. An update measures the lifetime since the
// previous rebuild, adds it to saturating totals, runs the 0.9/0.1 moving
// averages of mean (Q.8) and variance (Q.16) and schedules the next check at
// step + trunc(mean - 2*sigma) - 1, or at step itself when the configuration bit
// is set. An update runs the radix-4 multiplier (squares of lifetime and
// deviation), the four-bit-a-cycle divide by ten and the one-bit-a-cycle
// square root. Reset, init and the unused opcode skip the arithmetic and
// go from decode through apply to the result register. A new word is taken
// the cycle after the result register loads, whether or not the result has
// been taken; the user must write the configuration bit only while idle,
// and the block itself does not enforce this.
`default_nettype none

module lifetime_ema_check_scheduler_unit #(
  parameter int LIFETIME_BITS = 20,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic                                 cfg_data,
  input  wire logic                                 in_valid,
  output      logic                                 in_ready,
  input  wire logic [1:0]                           opcode,
  input  wire logic [lecs_pkg::STEP_W-1:0]          step,
  input  wire logic [lecs_pkg::ATOMS_W-1:0]         atoms_beyond,
  output      logic                                 out_valid,
  input  wire logic                                 out_ready,
  output      logic signed [lecs_pkg::CHECK_W-1:0]  next_check_step,
  output      logic [lecs_pkg::LIFE_OUT_W-1:0]      lifetime,
  output      logic [lecs_pkg::MEAN_OUT_W-1:0]      mean_lifetime,
  output      logic [lecs_pkg::MEAN_OUT_W-1:0]      sigma,
  output      logic [lecs_pkg::COUNT_W-1:0]         rebuild_count,
  output      logic [lecs_pkg::SUM_W-1:0]           lifetime_sum,
  output      logic [lecs_pkg::SQSUM_W-1:0]         lifetime_square_sum,
  output      logic [lecs_pkg::TOTAL_W-1:0]         atoms_beyond_total
);

  lecs_pkg::cmd_t    cmd;
  lecs_pkg::status_t status;

  lecs_ctrl #(
    .LIFETIME_BITS(LIFETIME_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lecs_dp #(
    .LIFETIME_BITS(LIFETIME_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg_write),
    .cfg_data            (cfg_data),
    .opcode              (opcode),
    .step                (step),
    .atoms_beyond        (atoms_beyond),
    .cmd                 (cmd),
    .status              (status),
    .next_check_step     (next_check_step),
    .lifetime            (lifetime),
    .mean_lifetime       (mean_lifetime),
    .sigma               (sigma),
    .rebuild_count       (rebuild_count),
    .lifetime_sum        (lifetime_sum),
    .lifetime_square_sum (lifetime_square_sum),
    .atoms_beyond_total  (atoms_beyond_total)
  );

endmodule

`default_nettype wire

// ===== tb/lifetime_ema_check_scheduler_unit_test.sv =====
// Testbench for lifetime_ema_check_scheduler_unit: directed and random rebuild events,
// checked word by word against an in-bench model of the lifetime statistics and schedule.
// Depends on lecs_pkg and the design sources.
`timescale 1ns / 100ps

module lifetime_ema_check_scheduler_unit_test;

  localparam int FRAC = 8;
  localparam logic [63:0] LIFE_MAX  = (64'd1 << 20) - 64'd1;
  localparam logic [63:0] MEAN_MASK = (64'd1 << (20 + FRAC)) - 64'd1;
  localparam logic [63:0] MAX32 = (64'd1 << 32) - 64'd1;
  localparam logic [63:0] MAX48 = (64'd1 << 48) - 64'd1;
  localparam logic [63:0] MAX50 = (64'd1 << 50) - 64'd1;
  localparam logic [63:0] MAX63 = (64'd1 << 63) - 64'd1;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [lecs_pkg::CHECK_W-1:0]    check;
    logic [lecs_pkg::LIFE_OUT_W-1:0] life;
    logic [lecs_pkg::MEAN_OUT_W-1:0] mean;
    logic [lecs_pkg::MEAN_OUT_W-1:0] sig;
    logic [lecs_pkg::COUNT_W-1:0]    count;
    logic [lecs_pkg::SUM_W-1:0]      sum;
    logic [lecs_pkg::SQSUM_W-1:0]    sqsum;
    logic [lecs_pkg::TOTAL_W-1:0]    atoms;
  } sched_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = lecs_pkg::OP_UPDATE;
  logic [lecs_pkg::STEP_W-1:0] step = '0;
  logic [lecs_pkg::ATOMS_W-1:0] atoms_beyond = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [lecs_pkg::CHECK_W-1:0] next_check_step;
  logic [lecs_pkg::LIFE_OUT_W-1:0] lifetime;
  logic [lecs_pkg::MEAN_OUT_W-1:0] mean_lifetime;
  logic [lecs_pkg::MEAN_OUT_W-1:0] sigma;
  logic [lecs_pkg::COUNT_W-1:0] rebuild_count;
  logic [lecs_pkg::SUM_W-1:0] lifetime_sum;
  logic [lecs_pkg::SQSUM_W-1:0] lifetime_square_sum;
  logic [lecs_pkg::TOTAL_W-1:0] atoms_beyond_total;

  lifetime_ema_check_scheduler_unit dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .step(step),
    .atoms_beyond(atoms_beyond), .out_valid(out_valid), .out_ready(out_ready),
    .next_check_step(next_check_step), .lifetime(lifetime),
    .mean_lifetime(mean_lifetime), .sigma(sigma), .rebuild_count(rebuild_count),
    .lifetime_sum(lifetime_sum), .lifetime_square_sum(lifetime_square_sum),
    .atoms_beyond_total(atoms_beyond_total)
  );

  // model state
  logic        every_step_cfg = 1'b0;
  logic [63:0] last_step_m = '0;
  logic [63:0] check_m = '0;
  logic [63:0] mean_m = '0;
  logic [63:0] var_m = '0;
  logic [63:0] count_m = '0;
  logic [63:0] sum_m = '0;
  logic [63:0] sqsum_m = '0;
  logic [63:0] atoms_m = '0;

  sched_word_t expected_words[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] max);
    if (a >= max || b > max - a) return max;
    return a + b;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem = v;
    root = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic sched_word_t predict_schedule(input logic [1:0] op,
                                                   input logic [47:0] st,
                                                   input logic [23:0] at);
    sched_word_t w;
    logic [63:0] st64;
    logic [63:0] lt;
    logic [63:0] ltf;
    logic [63:0] half;
    logic [63:0] dd;
    logic [63:0] sg;
    longint dm;
    longint trunc_d;
    st64 = {16'd0, st};
    lt = '0;
    if (op == lecs_pkg::OP_RESET || op == lecs_pkg::OP_INIT) begin
      if (op == lecs_pkg::OP_INIT) begin
        count_m = '0;
        sum_m = '0;
        sqsum_m = '0;
        atoms_m = '0;
      end
      mean_m = '0;
      var_m = '0;
      check_m = st64;
      last_step_m = st64;
    end else if (op == lecs_pkg::OP_UPDATE) begin
      if (st64 > last_step_m) begin
        lt = st64 - last_step_m;
        if (lt > LIFE_MAX) lt = LIFE_MAX;
      end
      count_m = sat_add(count_m, 64'd1, MAX32);
      sum_m = sat_add(sum_m, lt, MAX48);
      sqsum_m = sat_add(sqsum_m, lt * lt, MAX63);
      atoms_m = sat_add(atoms_m, {40'd0, at}, MAX48);
      ltf = lt << FRAC;
      if (mean_m == 0) begin
        half = lt << (FRAC - 1);
        mean_m = ltf;
        var_m = half * half;
      end
      dd = (mean_m >= ltf) ? mean_m - ltf : ltf - mean_m;
      var_m = (64'd9 * var_m + dd * dd) / 64'd10;
      mean_m = ((64'd9 * mean_m + ltf) / 64'd10) & MEAN_MASK;
      if (every_step_cfg) begin
        check_m = st64;
      end else begin
        sg = int_sqrt(var_m);
        dm = longint'(mean_m) - 2 * longint'(sg);
        trunc_d = dm / (longint'(1) << FRAC);
        check_m = (st64 + trunc_d - 64'd1) & MAX50;
      end
      last_step_m = st64;
    end
    sg = int_sqrt(var_m);
    w.check = check_m[lecs_pkg::CHECK_W-1:0];
    w.life = lt[lecs_pkg::LIFE_OUT_W-1:0];
    w.mean = mean_m[lecs_pkg::MEAN_OUT_W-1:0];
    w.sig = sg[lecs_pkg::MEAN_OUT_W-1:0];
    w.count = count_m[lecs_pkg::COUNT_W-1:0];
    w.sum = sum_m[lecs_pkg::SUM_W-1:0];
    w.sqsum = sqsum_m[lecs_pkg::SQSUM_W-1:0];
    w.atoms = atoms_m[lecs_pkg::TOTAL_W-1:0];
    return w;
  endfunction

  // result side: random stalls and comparison against the oldest expected word
  always @(posedge clk) begin
    sched_word_t got;
    sched_word_t exp_w;
    got = '{next_check_step, lifetime, mean_lifetime, sigma, rebuild_count,
            lifetime_sum, lifetime_square_sum, atoms_beyond_total};
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result word: chk=%h lt=%h mean=%h sig=%h", got.check,
                   got.life, got.mean, got.sig);
        mismatch_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (got !== exp_w) begin
          if (mismatch_count < 10) begin
            $display("mismatch exp: chk=%h lt=%h mean=%h sig=%h cnt=%h sum=%h sq=%h at=%h",
                     exp_w.check, exp_w.life, exp_w.mean, exp_w.sig, exp_w.count,
                     exp_w.sum, exp_w.sqsum, exp_w.atoms);
            $display("         got: chk=%h lt=%h mean=%h sig=%h cnt=%h sum=%h sq=%h at=%h",
                     got.check, got.life, got.mean, got.sig, got.count,
                     got.sum, got.sqsum, got.atoms);
          end
          mismatch_count++;
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [47:0] st,
                           input logic [23:0] at);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    step <= st;
    atoms_beyond <= at;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_words.push_back(predict_schedule(op, st, at));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_every_step(input logic v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    every_step_cfg = v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_stream(input int n, input int unsigned idle_pct,
                            input int unsigned stall_pct, input logic every);
    logic [47:0] cur;
    logic [23:0] at;
    logic [1:0] op;
    int base;
    int lt;
    int sent;
    int r;
    set_every_step(every);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    cur = 48'({$urandom, $urandom});
    if ($urandom_range(0, 1)) cur = {16'd0, $urandom} & 48'h0000_00FF_FFFF;
    base = 1;
    sent = 0;
    r = 0;
    while (sent < n) begin
      case ($urandom_range(0, 3))
        0: at = 24'($urandom_range(0, 255));
        1: at = 24'($urandom);
        2: at = {lecs_pkg::ATOMS_W{1'b1}};
        default: at = 24'($urandom_range(0, 15));
      endcase
      op = lecs_pkg::OP_UPDATE;
      if (sent != 0) r = $urandom_range(0, 99);
      if (sent == 0 || r < 3 || r < 6) begin
        op = (sent == 0 || r < 3) ? lecs_pkg::OP_INIT : lecs_pkg::OP_RESET;
        if ($urandom_range(0, 3) == 0) cur = 48'({$urandom, $urandom});
        else cur = cur + $urandom_range(0, 1000);
        case ($urandom_range(0, 3))
          0: base = $urandom_range(1, 16);
          1: base = $urandom_range(10, 300);
          2: base = $urandom_range(300, 20000);
          default: base = $urandom_range(20000, 1100000);
        endcase
      end else if (r < 8) begin
        op = OP_UNUSED;
        send_word(op, 48'({$urandom, $urandom}), 24'($urandom));
        continue;
      end else if (r < 11) begin
        cur = cur - $urandom_range(1, 5000);
      end else if (r < 13) begin
        cur = cur + $urandom_range(1 << 20, 1 << 26);
      end else if (r < 15) begin
        cur = 48'({$urandom, $urandom});
      end else if (r < 17) begin
        cur = cur;
      end else begin
        lt = base + $urandom_range(0, base) - base / 2;
        if (lt < 0) lt = 0;
        cur = cur + lt;
      end
      send_word(op, cur, at);
      sent++;
    end
    wait_idle();
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_every_step(1'b0);
    send_word(lecs_pkg::OP_INIT, 48'd0, 24'd0);
    send_word(lecs_pkg::OP_UPDATE, 48'd0, 24'd0);                 // zero lifetime, check goes negative
    send_word(lecs_pkg::OP_UPDATE, 48'd1, {lecs_pkg::ATOMS_W{1'b1}});
    send_word(lecs_pkg::OP_UPDATE, 48'd3, 24'd5);
    send_word(lecs_pkg::OP_UPDATE, 48'd10, 24'd1);
    send_word(lecs_pkg::OP_UPDATE, 48'd2, 24'd2);                 // step behind last rebuild
    send_word(lecs_pkg::OP_UPDATE, 48'd2 + (48'd1 << 20) + 48'd5, 24'd3);  // lifetime saturates
    send_word(lecs_pkg::OP_UPDATE, 48'd2 + (48'd1 << 20) + 48'd12, 24'd0);
    send_word(lecs_pkg::OP_RESET, 48'd5000, 24'd9);
    send_word(lecs_pkg::OP_UPDATE, 48'd5100, 24'd4);
    send_word(lecs_pkg::OP_UPDATE, 48'd5150, 24'd4);
    send_word(OP_UNUSED, {lecs_pkg::STEP_W{1'b1}}, {lecs_pkg::ATOMS_W{1'b1}});
    send_word(lecs_pkg::OP_UPDATE, 48'd5300, 24'd7);
    send_word(lecs_pkg::OP_INIT, 48'hFFFF_FFFF_FFF0, 24'd0);
    send_word(lecs_pkg::OP_UPDATE, {lecs_pkg::STEP_W{1'b1}}, {lecs_pkg::ATOMS_W{1'b1}});
    send_word(lecs_pkg::OP_UPDATE, 48'd5, 24'd1);                 // wrapped step
    wait_idle();
    set_every_step(1'b1);
    send_word(lecs_pkg::OP_UPDATE, 48'd105, 24'd1);
    send_word(lecs_pkg::OP_UPDATE, 48'd195, 24'd1);
    send_word(lecs_pkg::OP_RESET, 48'd200, 24'd1);
    send_word(lecs_pkg::OP_UPDATE, 48'd250, 24'd1);
    wait_idle();
    set_every_step(1'b0);
    send_word(lecs_pkg::OP_UPDATE, 48'd300, 24'd1);
    send_word(lecs_pkg::OP_UPDATE, 48'd360, 24'd1);
    send_word(lecs_pkg::OP_UPDATE, 48'd361, 24'd1);
    wait_idle();
  endtask

  task automatic test_stream_no_idle();
    run_stream(150, 0, 0, 1'b0);
  endtask

  task automatic test_stream_sender_gaps();
    run_stream(75, 46, 0, 1'b1);
    run_stream(75, 46, 0, 1'b0);
  endtask

  task automatic test_stream_receiver_stalls();
    run_stream(150, 0, 46, 1'b0);
  endtask

  task automatic test_stream_both_idle();
    run_stream(150, 6, 6, 1'b0);
  endtask

  initial begin
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_stream_no_idle();
    test_stream_sender_gaps();
    test_stream_receiver_stalls();
    test_stream_both_idle();
    wait_idle();
    repeat (90) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
